// ----- hdl/rdps_pkg.sv -----
// Shared constants, types and the quarter-wave sine table for the polar sampler.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package rdps_pkg;

    // Frame geometry
    localparam int FRAME_BITS = 6;
    localparam int FRAME_SIZE = 1 << FRAME_BITS;
    localparam int ADDR_BITS  = 2 * FRAME_BITS;
    localparam int COLOR_BITS = 24;

    // LED bar
    localparam int MAX_LEDS   = 64;
    localparam int LED_BITS   = 6;
    localparam int COUNT_BITS = 7;
    localparam logic [COUNT_BITS-1:0] LED_COUNT_RESET = COUNT_BITS'(32);
    localparam logic [COUNT_BITS-1:0] MIN_LED_COUNT   = COUNT_BITS'(2);
    localparam logic [COUNT_BITS-1:0] MAX_LED_COUNT   = COUNT_BITS'(MAX_LEDS);

    // Angle and fixed point (Q16 fractions)
    localparam int ANGLE_BITS    = 10;
    localparam int PHASE_BITS    = ANGLE_BITS - 2;
    localparam int QUARTER_STEPS = 1 << PHASE_BITS;
    localparam int MAG_BITS      = 17;              // sine magnitude, up to 1.0
    localparam int TRIG_BITS     = MAG_BITS + 1;    // signed sine / cosine
    localparam int OFF_BITS      = 17;              // signed LED offset, -0.5 .. 0.5
    localparam int PROD_BITS     = TRIG_BITS + OFF_BITS;
    localparam int DIV_BITS      = 17;              // width of the constant dividend 1.0
    localparam logic [DIV_BITS-1:0] ONE_Q16  = DIV_BITS'(65536);
    localparam logic [DIV_BITS:0]   HALF_Q16 = (DIV_BITS+1)'(32768);

    // Stream packing
    localparam int S_TDATA_BITS = 48;
    localparam int M_TDATA_BITS = 32;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [MAG_BITS-1:0] sine_table_t [0:QUARTER_STEPS-1];

    // Taylor series of sin over a quarter wave, Q30 internally, rounded to Q16
    function automatic logic [MAG_BITS-1:0] quarter_sine(input int unsigned p);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        t    = (64'(p) * HALF_PI_Q30) >> PHASE_BITS;
        t2   = (t * t) >> 30;
        term = t;
        sum  = t;
        term = ((term * t2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * t2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * t2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * t2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * t2) >> 30) / 64'd110;
        sum  = sum - term;
        r    = (sum + 64'd8192) >> 14;
        if (r > 64'd65536) begin
            r = 64'd65536;
        end
        return r[MAG_BITS-1:0];
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        for (int p = 0; p < QUARTER_STEPS; p++) begin
            tbl[p] = quarter_sine(p);
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();
    localparam logic [MAG_BITS-1:0] SINE_PEAK = quarter_sine(QUARTER_STEPS);

endpackage

`default_nettype wire

// ----- hdl/rdps_frame_store.sv -----
// Frame store memory: one write port, one registered read port.
// Depends on rdps_pkg for the address and color widths.
`default_nettype none

module rdps_frame_store
    import rdps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_BITS-1:0]  wr_addr,
    input  wire logic [COLOR_BITS-1:0] wr_data,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_BITS-1:0]  rd_addr,
    output logic      [COLOR_BITS-1:0] rd_data
);

    logic [COLOR_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rdps_divider.sv -----
// Restoring divider: one quotient bit per cycle of 1.0 (Q16) by the LED span.
// Depends on rdps_pkg for DIV_BITS and LED_BITS.
`default_nettype none

module rdps_divider
    import rdps_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [LED_BITS-1:0] divisor,
    output logic      [DIV_BITS-1:0] quotient,
    output logic      [LED_BITS-1:0] remainder,
    output logic                     done
);

    localparam int CNT_BITS = $clog2(DIV_BITS);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [DIV_BITS-1:0] dvd_reg;
    logic [DIV_BITS-1:0] quo_reg;
    logic [LED_BITS-1:0] rem_reg;
    logic [LED_BITS-1:0] dsr_reg;

    logic [LED_BITS:0]   trial;
    logic [LED_BITS:0]   diff;
    logic                fits;

    // Trial subtract of the divisor from the shifted partial remainder
    assign trial = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CNT_BITS'(DIV_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Datapath: shift in one dividend bit, produce one quotient bit
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= ONE_Q16;
            quo_reg <= '0;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIV_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_BITS-2:0], fits};
            rem_reg <= fits ? diff[LED_BITS-1:0] : trial[LED_BITS-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

// ----- hdl/rdps_coord_unit.sv -----
// Shared multiplier: direction times LED offset, then scale, round and clamp
// to a frame coordinate. Depends on rdps_pkg for the fixed-point widths.
`default_nettype none

module rdps_coord_unit
    import rdps_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic signed [TRIG_BITS-1:0] dir,
    input  wire logic signed [OFF_BITS-1:0]  off,
    output logic             [FRAME_BITS-1:0] coord
);

    // 0.5 in Q32 plus half a frame step, so the shift below rounds half up
    localparam logic signed [PROD_BITS-1:0] BIAS =
        PROD_BITS'((64'd1 << 31) + (64'd1 << (31 - FRAME_BITS)));

    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [PROD_BITS-1:0]  rel;
    logic        [FRAME_BITS:0]   scaled;

    // Register the product; the sequencer picks the operand each cycle
    always_ff @(posedge aclk) begin
        prod_reg <= dir * off;
    end

    // Scale by the frame size and clamp the top edge
    assign rel    = prod_reg + BIAS;
    assign scaled = rel[32 -: FRAME_BITS+1];
    assign coord  = scaled[FRAME_BITS] ? {FRAME_BITS{1'b1}} : scaled[FRAME_BITS-1:0];

endmodule

`default_nettype wire

// ----- hdl/rotating_display_polar_sampler.sv -----
// Polar sampler top level: frame store writes, LED bar draws, output register.
// Pixel write: written to the frame store as it is accepted. Draw: one 17-step
// divide, then the states sine, cosine, read and emit for each LED through the shared
// multiplier and the frame store read port; the emit state waits while the output stalls.
// Reset: a clearing pass zeroes the 4096-pixel frame store with s_tready low;
// led_count returns to 32.
`default_nettype none

module rotating_display_polar_sampler
    import rdps_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // Configuration: led_count
    input  wire logic                    cfg_wr_en,
    input  wire logic [COUNT_BITS-1:0]   cfg_wr_data,
    // Input items
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // pixel_x[5:0], pixel_y[11:6], pixel_color[35:12], rotation[45:36], zero pad
    input  wire logic [S_TDATA_BITS-1:0] s_tdata,
    // operation[0]
    input  wire logic                    s_tuser,
    // Result items
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // led_index[5:0], led_color[29:6], zero pad
    output logic      [M_TDATA_BITS-1:0] m_tdata,
    // last_led
    output logic                         m_tlast
);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DRAW  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SIN,
        ST_COS,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t                       state_reg;
    logic [ADDR_BITS-1:0]         clr_addr_reg;
    logic [COUNT_BITS-1:0]        led_count_reg;
    logic signed [TRIG_BITS-1:0]  sin_reg;
    logic signed [TRIG_BITS-1:0]  cos_reg;
    logic [LED_BITS-1:0]          span_reg;
    logic [LED_BITS-1:0]          idx_reg;
    logic [DIV_BITS-1:0]          q_step_reg;
    logic [LED_BITS-1:0]          r_step_reg;
    logic [DIV_BITS-1:0]          q_reg;
    logic [LED_BITS:0]            r_reg;
    logic [FRAME_BITS-1:0]        x_reg;
    logic                         m_tvalid_reg;
    logic [M_TDATA_BITS-1:0]      m_tdata_reg;
    logic                         m_tlast_reg;

    logic [FRAME_BITS-1:0]        in_x;
    logic [FRAME_BITS-1:0]        in_y;
    logic [COLOR_BITS-1:0]        in_color;
    logic [ANGLE_BITS-1:0]        in_rot;
    logic                         accept;
    logic                         draw_accept;
    logic [COUNT_BITS-1:0]        count_w;
    logic [LED_BITS-1:0]          span_w;
    logic [LED_BITS:0]            r_sum;
    logic                         r_wrap;
    logic [DIV_BITS:0]            off_full;
    logic signed [OFF_BITS-1:0]   off_w;
    logic signed [TRIG_BITS-1:0]  dir_w;
    logic [FRAME_BITS-1:0]        coord_w;
    logic                         out_free;
    logic                         wr_en;
    logic [ADDR_BITS-1:0]         wr_addr;
    logic [COLOR_BITS-1:0]        wr_data;
    logic                         rd_en;
    logic [COLOR_BITS-1:0]        rd_data;
    logic                         div_done;
    logic [DIV_BITS-1:0]          div_quo;
    logic [LED_BITS-1:0]          div_rem;

    // Signed Q16 sine from the quarter-wave table
    function automatic logic signed [TRIG_BITS-1:0] sine_q16(input logic [ANGLE_BITS-1:0] a);
        logic [1:0]            quad;
        logic [PHASE_BITS-1:0] p;
        logic [MAG_BITS-1:0]   m;
        quad = a[ANGLE_BITS-1 -: 2];
        p    = a[PHASE_BITS-1:0];
        if (quad[0]) begin
            m = (p == '0) ? SINE_PEAK : SINE_TABLE[PHASE_BITS'(0) - p];
        end else begin
            m = SINE_TABLE[p];
        end
        return quad[1] ? -signed'({1'b0, m}) : signed'({1'b0, m});
    endfunction

    // Unpack the input transaction
    assign in_x     = s_tdata[5:0];
    assign in_y     = s_tdata[11:6];
    assign in_color = s_tdata[35:12];
    assign in_rot   = s_tdata[45:36];

    assign s_tready    = (state_reg == ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign draw_accept = accept && (s_tuser == OP_DRAW);

    // Clamp the LED count into the supported range
    always_comb begin
        if (led_count_reg < MIN_LED_COUNT) begin
            count_w = MIN_LED_COUNT;
        end else if (led_count_reg > MAX_LED_COUNT) begin
            count_w = MAX_LED_COUNT;
        end else begin
            count_w = led_count_reg;
        end
    end
    assign span_w = LED_BITS'(count_w - 1'b1);

    // Offset of the current LED: quotient minus one half
    assign off_full = {1'b0, q_reg} - HALF_Q16;
    assign off_w    = off_full[OFF_BITS-1:0];

    // Next remainder of the running division i*1.0/span
    assign r_sum  = r_reg + {1'b0, r_step_reg};
    assign r_wrap = (r_sum >= {1'b0, span_reg});

    // Shared multiplier operand: sine first, cosine next
    assign dir_w = (state_reg == ST_SIN) ? sin_reg : cos_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    // Frame store ports: clearing pass or pixel write; read during a draw
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end else begin
            wr_en   = accept && (s_tuser == OP_WRITE);
            wr_addr = {in_x, in_y};
            wr_data = in_color;
        end
    end
    assign rd_en = (state_reg == ST_READ);

    rdps_frame_store u_frame_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr ({x_reg, coord_w}),
        .rd_data (rd_data)
    );

    rdps_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (draw_accept),
        .divisor   (span_w),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    rdps_coord_unit u_coord_unit (
        .aclk  (aclk),
        .dir   (dir_w),
        .off   (off_w),
        .coord (coord_w)
    );

    // Sequencer and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            led_count_reg <= LED_COUNT_RESET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                led_count_reg <= cfg_wr_data;
            end

            // Drop the output once the transaction completes; the emit state
            // reloads it on its own
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == {ADDR_BITS{1'b1}}) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (draw_accept) begin
                        sin_reg   <= sine_q16(in_rot);
                        cos_reg   <= sine_q16(in_rot + ANGLE_BITS'(QUARTER_STEPS));
                        span_reg  <= span_w;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        q_step_reg <= div_quo;
                        r_step_reg <= div_rem;
                        q_reg      <= '0;
                        r_reg      <= {2'b00, span_reg[LED_BITS-1:1]};
                        idx_reg    <= '0;
                        state_reg  <= ST_SIN;
                    end
                end
                ST_SIN: begin
                    state_reg <= ST_COS;
                end
                ST_COS: begin
                    x_reg     <= coord_w;
                    state_reg <= ST_READ;
                end
                ST_READ: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{(M_TDATA_BITS-COLOR_BITS-LED_BITS){1'b0}},
                                         rd_data, idx_reg};
                        m_tlast_reg  <= (idx_reg == span_reg);
                        if (idx_reg == span_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            // Advance to the next LED
                            idx_reg <= idx_reg + 1'b1;
                            if (r_wrap) begin
                                r_reg <= r_sum - {1'b0, span_reg};
                                q_reg <= q_reg + q_step_reg + 1'b1;
                            end else begin
                                r_reg <= r_sum;
                                q_reg <= q_reg + q_step_reg;
                            end
                            state_reg <= ST_SIN;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ----- bench/rdps_tb_pkg.sv -----
// Bench-side types for the polar sampler: command codes and the LED sample record.
// Depends on rdps_pkg for field widths; used by rdps_checker and tb_top.
package rdps_tb_pkg;
    import rdps_pkg::*;

    // Command carried in s_tuser
    typedef enum logic {
        OP_PIXEL_WRITE = 1'b0,
        OP_DRAW        = 1'b1
    } sampler_op_t;

    // One expected LED result
    typedef struct packed {
        logic [LED_BITS-1:0]   led_index;
        logic [COLOR_BITS-1:0] led_color;
        logic                  last_led;
    } led_sample_t;

endpackage

// ----- bench/rdps_checker.sv -----
// Checker for the polar sampler: shadows the frame store and led_count, predicts
// every LED color of a draw and compares the result stream. Needs rdps_pkg, rdps_tb_pkg.
module rdps_checker
    import rdps_pkg::*, rdps_tb_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [COUNT_BITS-1:0]   cfg_wr_data,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tready,
    input  wire logic [S_TDATA_BITS-1:0] s_tdata,
    input  wire logic                    s_tuser,
    input  wire logic                    m_tvalid,
    input  wire logic                    m_tready,
    input  wire logic [M_TDATA_BITS-1:0] m_tdata,
    input  wire logic                    m_tlast,
    output int                           error_count,
    output int                           pending_samples,
    output int                           draws_seen,
    output int                           samples_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [MAG_BITS-1:0]   quarter_lut [0:QUARTER_STEPS];
    logic [COLOR_BITS-1:0] pixel_mem [0:FRAME_SIZE*FRAME_SIZE-1];
    logic [COUNT_BITS-1:0] bar_leds;
    led_sample_t           expected_leds [$];

    // Quarter-wave sine magnitude in Q16 from a Q30 Taylor series
    function automatic logic [MAG_BITS-1:0] quarter_wave(input int unsigned phase);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] term;
        logic [63:0] acc;
        int          k;
        ang    = (64'(phase) * 64'd1686629713) >> PHASE_BITS;
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = ang;
        for (k = 1; k <= 5; k++) begin
            term = ((term * ang_sq) >> 30) / 64'(4 * k * k + 2 * k);
            if (k % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        acc = (acc + 64'd8192) >> 14;
        return (acc > 64'd65536) ? MAG_BITS'(65536) : acc[MAG_BITS-1:0];
    endfunction

    // Full-turn signed sine from the quarter table
    function automatic longint signed_sine(input logic [ANGLE_BITS-1:0] angle);
        logic [1:0]            quad;
        logic [PHASE_BITS-1:0] phase;
        longint                mag;
        quad  = angle[ANGLE_BITS-1 -: 2];
        phase = angle[PHASE_BITS-1:0];
        mag   = quad[0] ? longint'(quarter_lut[QUARTER_STEPS - int'(phase)])
                        : longint'(quarter_lut[phase]);
        return quad[1] ? -mag : mag;
    endfunction

    // 0.5 + dir*off in Q32, scaled to the frame, rounded half up and clamped
    function automatic int unsigned bar_coord(input longint dir, input longint off);
        logic [63:0] rel;
        logic [63:0] scaled;
        rel    = 64'd2147483648 + 64'(dir * off);
        scaled = (rel * 64'(FRAME_SIZE) + 64'd2147483648) >> 32;
        return (scaled > 64'(FRAME_SIZE - 1)) ? FRAME_SIZE - 1 : int'(scaled);
    endfunction

    // Queue the colors under every LED of the bar at this angle
    function automatic void predict_bar(input logic [ANGLE_BITS-1:0] angle);
        int unsigned lit;
        int unsigned span;
        int unsigned led;
        int unsigned col;
        int unsigned row;
        longint      sin_q16;
        longint      cos_q16;
        longint      off;
        led_sample_t want;
        lit = int'(bar_leds);
        if (bar_leds < MIN_LED_COUNT) begin
            lit = int'(MIN_LED_COUNT);
        end
        if (bar_leds > MAX_LED_COUNT) begin
            lit = int'(MAX_LED_COUNT);
        end
        span    = lit - 1;
        sin_q16 = signed_sine(angle);
        cos_q16 = signed_sine(angle + ANGLE_BITS'(QUARTER_STEPS));
        for (led = 0; led < lit; led++) begin
            off = longint'((led * 65536 + span / 2) / span) - 64'sd32768;
            col = bar_coord(sin_q16, off);
            row = bar_coord(cos_q16, off);
            want.led_index = LED_BITS'(led);
            want.led_color = pixel_mem[col * FRAME_SIZE + row];
            want.last_led  = (led == span);
            expected_leds.push_back(want);
        end
    endfunction

    initial begin : build_lut
        int p;
        error_count     = 0;
        pending_samples = 0;
        draws_seen      = 0;
        samples_checked = 0;
        for (p = 0; p <= QUARTER_STEPS; p++) begin
            quarter_lut[p] = quarter_wave(p);
        end
    end

    // Track writes and draws, check each LED transaction against the oldest expectation
    always @(posedge aclk) begin : monitor
        led_sample_t           want;
        logic [LED_BITS-1:0]   got_index;
        logic [COLOR_BITS-1:0] got_color;
        int                    j;
        if (!aresetn) begin
            for (j = 0; j < FRAME_SIZE * FRAME_SIZE; j++) begin
                pixel_mem[j] = '0;
            end
            bar_leds = LED_COUNT_RESET;
            expected_leds.delete();
        end else begin
            if (cfg_wr_en) begin
                bar_leds = cfg_wr_data;
            end
            if (m_tvalid && m_tready) begin
                got_index = m_tdata[LED_BITS-1:0];
                got_color = m_tdata[LED_BITS +: COLOR_BITS];
                if (expected_leds.size() == 0) begin
                    $error("LED transaction with nothing expected: led_index %0d", got_index);
                    error_count++;
                end else begin
                    want = expected_leds.pop_front();
                    samples_checked++;
                    if (got_index !== want.led_index) begin
                        $error("led_index mismatch: expected %0d, actual %0d",
                               want.led_index, got_index);
                        error_count++;
                    end
                    if (got_color !== want.led_color) begin
                        $error("led_color mismatch: expected %06h, actual %06h",
                               want.led_color, got_color);
                        error_count++;
                    end
                    if (m_tlast !== want.last_led) begin
                        $error("last_led mismatch: expected %0b, actual %0b",
                               want.last_led, m_tlast);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_DRAW) begin
                    draws_seen++;
                    predict_bar(s_tdata[36 +: ANGLE_BITS]);
                end else begin
                    pixel_mem[{s_tdata[5:0], s_tdata[11:6]}] = s_tdata[12 +: COLOR_BITS];
                end
            end
        end
        pending_samples = expected_leds.size();
    end

endmodule

// ----- bench/tb_top.sv -----
// Bench top for the polar sampler: clock, reset, command stimulus and verdict.
// Depends on rdps_pkg, rdps_tb_pkg, rdps_checker and the sampler RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rdps_pkg::*;
    import rdps_tb_pkg::*;

    localparam int RANDOM_ITEMS_PER_SETTING = 24;
    localparam int SETTLE_CYCLES            = 32;
    localparam int STALL_LIMIT              = 20000;
    localparam int SETTING_COUNT            = 9;

    logic                    aclk;
    logic                    aresetn     = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [COUNT_BITS-1:0]   cfg_wr_data = '0;
    logic                    s_tvalid    = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata     = '0;
    logic                    s_tuser     = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready    = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    m_tlast;

    bit no_idle          = 1'b0;
    int commands_sent    = 0;
    int settings_written = 0;
    int idle_cycles      = 0;
    int error_count;
    int pending_samples;
    int draws_seen;
    int samples_checked;

    logic [COUNT_BITS-1:0] count_plan [0:SETTING_COUNT-1] =
        '{7'd2, 7'd64, 7'd0, 7'd1, 7'd127, 7'd65, 7'd3, 7'd17, 7'd48};

    rotating_display_polar_sampler dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    rdps_checker bar_monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .error_count     (error_count),
        .pending_samples (pending_samples),
        .draws_seen      (draws_seen),
        .samples_checked (samples_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hold off a random number of cycles, then present one command until taken
    task automatic send_command(input sampler_op_t op, input logic [5:0] col,
                                input logic [5:0] row, input logic [23:0] color,
                                input logic [ANGLE_BITS-1:0] angle);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_BITS'({angle, color, row, col});
        do @(posedge aclk); while (!s_tready);
        commands_sent++;
    endtask

    // Frame coordinate of a bar position given as a fraction 0..1 of the width
    function automatic logic [5:0] grid_pos(input real rel);
        int pos;
        pos = $rtoi(rel * real'(FRAME_SIZE) + 0.5);
        return (pos > FRAME_SIZE - 1) ? 6'(FRAME_SIZE - 1) : 6'(pos);
    endfunction

    // Mix of stray writes, writes aimed onto some bar position, and draws
    task automatic send_random_command();
        int                    pick;
        real                   theta;
        real                   frac;
        logic [5:0]            col;
        logic [5:0]            row;
        logic [23:0]           color;
        logic [ANGLE_BITS-1:0] angle;
        pick  = $urandom_range(0, 99);
        col   = 6'($urandom);
        row   = 6'($urandom);
        color = 24'($urandom);
        angle = ANGLE_BITS'($urandom);
        if (pick < 25) begin
            send_command(OP_PIXEL_WRITE, col, row, color, angle);
        end else if (pick < 58) begin
            theta = 2.0 * 3.14159265358979 * real'($urandom_range(0, 1023)) / 1024.0;
            frac  = real'($urandom_range(0, 63)) / 63.0 - 0.5;
            col   = grid_pos(0.5 + $sin(theta) * frac);
            row   = grid_pos(0.5 + $cos(theta) * frac);
            send_command(OP_PIXEL_WRITE, col, row, color, angle);
        end else begin
            if ($urandom_range(0, 5) == 0) begin
                angle = ANGLE_BITS'(128 * $urandom_range(0, 7));
            end
            send_command(OP_DRAW, col, row, color, angle);
        end
    endtask

    // Drop valid, wait for every LED result, then let the pipeline settle
    task automatic wait_bar_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_samples != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_led_count(input logic [COUNT_BITS-1:0] value);
        wait_bar_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        settings_written++;
    endtask

    // Result side: random stall per LED transaction
    initial begin : led_sink
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        int                    setting_idx;
        int                    n;
        logic [COUNT_BITS-1:0] setting;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Corners, edge midpoints and center of the frame, at the reset LED count
        send_command(OP_PIXEL_WRITE, 6'd0, 6'd0, 24'hFFFFFF, 10'h3FF);
        send_command(OP_PIXEL_WRITE, 6'd63, 6'd63, 24'h000001, 10'h000);
        send_command(OP_PIXEL_WRITE, 6'd63, 6'd0, 24'h800000, 10'h2AA);
        send_command(OP_PIXEL_WRITE, 6'd0, 6'd63, 24'h7FFFFF, 10'h155);
        send_command(OP_PIXEL_WRITE, 6'd32, 6'd32, 24'hA5A5A5, 10'h3FF);
        send_command(OP_PIXEL_WRITE, 6'd31, 6'd31, 24'h5A5A5A, 10'h000);
        send_command(OP_PIXEL_WRITE, 6'd32, 6'd0, 24'h0F0F0F, 10'h0F0);
        send_command(OP_PIXEL_WRITE, 6'd32, 6'd63, 24'hF0F0F0, 10'h30F);
        send_command(OP_PIXEL_WRITE, 6'd0, 6'd32, 24'h123456, 10'h1C3);
        send_command(OP_PIXEL_WRITE, 6'd63, 6'd32, 24'h654321, 10'h23C);

        // Bar along both axes, diagonals and the last angle step
        send_command(OP_DRAW, 6'd63, 6'd63, 24'hFFFFFF, 10'd0);
        send_command(OP_DRAW, 6'd0, 6'd0, 24'h000000, 10'd256);
        send_command(OP_DRAW, 6'd21, 6'd42, 24'hC3C3C3, 10'd512);
        send_command(OP_DRAW, 6'd42, 6'd21, 24'h3C3C3C, 10'd768);
        send_command(OP_DRAW, 6'd63, 6'd0, 24'hFF00FF, 10'd1023);
        send_command(OP_DRAW, 6'd0, 6'd63, 24'h00FF00, 10'd128);
        send_command(OP_DRAW, 6'd5, 6'd58, 24'h0000FF, 10'd384);
        send_command(OP_DRAW, 6'd58, 6'd5, 24'hFF0000, 10'd640);
        send_command(OP_DRAW, 6'd17, 6'd46, 24'h777777, 10'd896);

        // Random traffic under each LED count, out-of-range counts included
        for (setting_idx = 0; setting_idx < SETTING_COUNT; setting_idx++) begin
            setting = (setting_idx == SETTING_COUNT - 1) ? COUNT_BITS'($urandom_range(0, 127))
                                                         : count_plan[setting_idx];
            write_led_count(setting);
            no_idle = (setting_idx % 3 == 1);
            for (n = 0; n < RANDOM_ITEMS_PER_SETTING; n++) begin
                send_random_command();
            end
        end
        no_idle = 1'b0;

        wait_bar_drained();
        $display("Run covered %0d commands (%0d draws) over %0d written LED counts plus reset",
                 commands_sent, draws_seen, settings_written);
        $display("Compared %0d LED samples field by field", samples_checked);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- rotating_display_polar_sampler.f -----
hdl/rdps_pkg.sv
hdl/rdps_frame_store.sv
hdl/rdps_divider.sv
hdl/rdps_coord_unit.sv
hdl/rotating_display_polar_sampler.sv
bench/rdps_tb_pkg.sv
bench/rdps_checker.sv
bench/tb_top.sv
